// ===== hw/rtl/bankers_deadlock_avoidance_top_defines.svh =====
// Assertion macros for the banker's deadlock-avoidance block.
// Used by modules that check their own control sequencing; expects clk and rst_n in scope.
`ifndef BANKERS_DEADLOCK_AVOIDANCE_TOP_DEFINES_SVH
`define BANKERS_DEADLOCK_AVOIDANCE_TOP_DEFINES_SVH

// same-cycle implication
`define BDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bda_pkg.sv =====
// Shared types and codes for the banker's deadlock-avoidance block.
// No dependencies; imported by bda_ctrl, bda_dp and the top level.
package bda_pkg;

  localparam int MAX_PROCS     = 8;
  localparam int MAX_RESOURCES = 4;
  localparam int COUNT_WIDTH   = 8;
  localparam int VEC_WIDTH     = 16;

  // item kinds
  localparam logic [2:0] T_CLAIM   = 3'd0;
  localparam logic [2:0] T_ALLOC   = 3'd1;
  localparam logic [2:0] T_AVAIL   = 3'd2;
  localparam logic [2:0] T_CHECK   = 3'd3;
  localparam logic [2:0] T_REQUEST = 3'd4;

  // result status codes
  localparam logic [2:0] ST_LOADED   = 3'd0;
  localparam logic [2:0] ST_SAFE     = 3'd1;
  localparam logic [2:0] ST_UNSAFE   = 3'd2;
  localparam logic [2:0] ST_GRANTED  = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;
  localparam logic [2:0] ST_EXCEEDS  = 3'd5;
  localparam logic [2:0] ST_WAIT     = 3'd6;
  localparam logic [2:0] ST_BUFFERED = 3'd7;

  // configuration register indexes
  localparam logic REG_PROCS = 1'b0;
  localparam logic REG_RES   = 1'b1;

  typedef struct packed {
    logic       load;       // store the item being transferred in
    logic       safe_init;
    logic       safe_step;
    logic       grant;
    logic       rollback;
    logic       clr_buf;
    logic       out_one;
    logic       out_rank;
    logic [2:0] status;
    logic [2:0] row;        // process row addressed this cycle
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] in_type;
    logic       in_last;
    logic [2:0] in_proc;
    logic [3:0] n_eff;
    logic [2:0] req_proc;
    logic       bad_proc;
    logic       over;
    logic       wait_req;
    logic       all_done;
  } dp_stat_t;

endpackage

// ===== hw/rtl/bankers_deadlock_avoidance_top.sv =====
// Channel  | Direction | Payload
// in_      | slave     | tdata: req_type[2:0] proc_index[5:3] res_index[7:6] amount[15:8]; tlast: last_element
// out_     | master    | tdata: status[2:0] proc_out[5:3] finish_rank[9:6]; tlast: last_result
// cfg_     | write     | cfg_addr 0 procs_in_use, 1 resources_in_use
// Loads and buffered elements go straight to a single result transfer; a safety check runs
// one process slot per cycle through the shared compare/add row unit, then n result transfers.
// A request first passes a check state before the pass. Reset is synchronous, active low; no clearing pass.
// Input is taken only when the engine is idle; a stalled result holds the engine before its next result transfer.
// Top level of the banker's deadlock-avoidance block; depends on bda_pkg, bda_ctrl, bda_dp.
module bankers_deadlock_avoidance_top import bda_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // req_type, proc_index, res_index, amount
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status, proc_out, finish_rank, zero fill
  output logic        out_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bda_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bda_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

// ===== hw/rtl/bda_dp.sv =====
// Datapath: allocation/need tables (claims are stored as need), available and work vectors, finishing ranks,
// request buffer, configuration and the output register. Depends on bda_pkg.
module bda_dp import bda_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [3:0]       cfg_wdata,
  input  logic [15:0]      in_tdata,
  input  logic             in_tlast,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output logic [15:0]      out_tdata,
  output logic             out_tlast
);

  logic [COUNT_WIDTH-1:0] alloc_r  [MAX_PROCS][MAX_RESOURCES];
  logic [COUNT_WIDTH:0]   need_r   [MAX_PROCS][MAX_RESOURCES];
  logic [VEC_WIDTH-1:0]   avail_r  [MAX_RESOURCES];
  logic [VEC_WIDTH-1:0]   work_r   [MAX_RESOURCES];
  logic [3:0]             rank_r   [MAX_PROCS];
  logic [COUNT_WIDTH-1:0] reqbuf_r [MAX_RESOURCES];
  logic [2:0]             reqproc_r;
  logic [3:0]             rank_cnt_r;
  logic [3:0]             procs_r;
  logic [2:0]             res_r;
  logic [2:0]             o_status_r;
  logic [2:0]             o_proc_r;
  logic [3:0]             o_rank_r;
  logic                   o_last_r;

  logic [2:0]             in_type, in_proc;
  logic [1:0]             in_res;
  logic [COUNT_WIDTH-1:0] in_amt;
  logic [3:0]             n_eff;
  logic [2:0]             m_eff;
  logic [MAX_RESOURCES-1:0] use_j, fit_j, over_j, wait_j;
  logic [VEC_WIDTH:0]     sum_j [MAX_RESOURCES];
  logic [MAX_PROCS-1:0]   done_j;
  logic                   fits;

  assign in_type = in_tdata[2:0];
  assign in_proc = in_tdata[5:3];
  assign in_res  = in_tdata[7:6];
  assign in_amt  = in_tdata[15:8];

  always_comb begin
    if (procs_r == 4'd0) n_eff = 4'd1;
    else if (procs_r > 4'(MAX_PROCS)) n_eff = 4'(MAX_PROCS);
    else n_eff = procs_r;
    if (res_r == 3'd0) m_eff = 3'd1;
    else if (res_r > 3'(MAX_RESOURCES)) m_eff = 3'(MAX_RESOURCES);
    else m_eff = res_r;
  end

  always_comb begin
    for (int j = 0; j < MAX_RESOURCES; j++) begin
      use_j[j]  = 3'(j) < m_eff;
      fit_j[j]  = !use_j[j] || need_r[cmd.row][j][COUNT_WIDTH] ||
                  (VEC_WIDTH'(need_r[cmd.row][j][COUNT_WIDTH-1:0]) <= work_r[j]);
      sum_j[j]  = {1'b0, work_r[j]} + (VEC_WIDTH+1)'(alloc_r[cmd.row][j]);
      over_j[j] = use_j[j] && (need_r[cmd.row][j][COUNT_WIDTH] ||
                  (reqbuf_r[j] > need_r[cmd.row][j][COUNT_WIDTH-1:0]));
      wait_j[j] = use_j[j] && (VEC_WIDTH'(reqbuf_r[j]) > avail_r[j]);
    end
    for (int i = 0; i < MAX_PROCS; i++) begin
      done_j[i] = (4'(i) >= n_eff) || (rank_r[i] != 4'd0);
    end
    fits = (&fit_j) && (rank_r[cmd.row] == 4'd0);
  end

  assign stat.in_type  = in_type;
  assign stat.in_last  = in_tlast;
  assign stat.in_proc  = in_proc;
  assign stat.n_eff    = n_eff;
  assign stat.req_proc = reqproc_r;
  assign stat.bad_proc = {1'b0, reqproc_r} >= n_eff;
  assign stat.over     = |over_j;
  assign stat.wait_req = |wait_j;
  assign stat.all_done = &done_j;

  // configuration and control-side counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      procs_r    <= 4'(MAX_PROCS);
      res_r      <= 3'(MAX_RESOURCES);
      rank_cnt_r <= 4'd1;
      reqproc_r  <= 3'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PROCS: procs_r <= cfg_wdata;
          REG_RES:   res_r   <= cfg_wdata[2:0];
          default:   ;
        endcase
      end
      if (cmd.load && in_type == T_REQUEST) reqproc_r <= in_proc;
      if (cmd.safe_init) rank_cnt_r <= 4'd1;
      else if (cmd.safe_step && fits) rank_cnt_r <= rank_cnt_r + 4'd1;
    end
  end

  // tables and vectors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        for (int j = 0; j < MAX_RESOURCES; j++) begin
          alloc_r[i][j] <= '0;
          need_r[i][j]  <= '0;
        end
      end
      for (int j = 0; j < MAX_RESOURCES; j++) begin
        avail_r[j]  <= '0;
        reqbuf_r[j] <= '0;
      end
    end else begin
      if (cmd.load) begin
        case (in_type)
          T_CLAIM: need_r[cmd.row][in_res] <= {1'b0, in_amt} - {1'b0, alloc_r[cmd.row][in_res]};
          T_ALLOC: begin
            need_r[cmd.row][in_res] <= need_r[cmd.row][in_res]
                                       + {1'b0, alloc_r[cmd.row][in_res]} - {1'b0, in_amt};
            alloc_r[cmd.row][in_res] <= in_amt;
          end
          T_AVAIL:   avail_r[in_res] <= VEC_WIDTH'(in_amt);
          T_REQUEST: reqbuf_r[in_res] <= in_amt;
          default:   ;
        endcase
      end
      for (int j = 0; j < MAX_RESOURCES; j++) begin
        if (use_j[j] && cmd.grant) begin
          avail_r[j]         <= avail_r[j] - VEC_WIDTH'(reqbuf_r[j]);
          alloc_r[cmd.row][j] <= alloc_r[cmd.row][j] + reqbuf_r[j];
          need_r[cmd.row][j]  <= need_r[cmd.row][j] - {1'b0, reqbuf_r[j]};
        end
        if (use_j[j] && cmd.rollback) begin
          avail_r[j]         <= avail_r[j] + VEC_WIDTH'(reqbuf_r[j]);
          alloc_r[cmd.row][j] <= alloc_r[cmd.row][j] - reqbuf_r[j];
          need_r[cmd.row][j]  <= need_r[cmd.row][j] + {1'b0, reqbuf_r[j]};
        end
        if (cmd.clr_buf) reqbuf_r[j] <= '0;
      end
    end
  end

  // safety pass state: undefined until written, no reset
  always_ff @(posedge clk) begin
    if (cmd.safe_init) begin
      for (int j = 0; j < MAX_RESOURCES; j++) work_r[j] <= avail_r[j];
      for (int i = 0; i < MAX_PROCS; i++) rank_r[i] <= 4'd0;
    end else if (cmd.safe_step && fits) begin
      for (int j = 0; j < MAX_RESOURCES; j++) begin
        // saturate at the vector maximum
        work_r[j] <= sum_j[j][VEC_WIDTH] ? '1 : sum_j[j][VEC_WIDTH-1:0];
      end
      rank_r[cmd.row] <= rank_cnt_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_one) begin
      o_status_r <= cmd.status;
      o_proc_r   <= 3'd0;
      o_rank_r   <= 4'd0;
      o_last_r   <= 1'b1;
    end else if (cmd.out_rank) begin
      o_status_r <= cmd.status;
      o_proc_r   <= cmd.row;
      o_rank_r   <= rank_r[cmd.row];
      o_last_r   <= ({1'b0, cmd.row} == n_eff - 4'd1);
    end
  end

  assign out_tdata = {6'd0, o_rank_r, o_proc_r, o_status_r};
  assign out_tlast = o_last_r;

endmodule

// ===== hw/rtl/bda_ctrl.sv =====
// Controller: sequences loads, request checks, the round-robin safety pass and result
// transfers. Depends on bda_pkg and bankers_deadlock_avoidance_top_defines.svh.
`include "bankers_deadlock_avoidance_top_defines.svh"
module bda_ctrl import bda_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REQ    = 3'd1;
  localparam logic [2:0] S_INIT   = 3'd2;
  localparam logic [2:0] S_STEP   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;
  localparam logic [2:0] S_EMIT1  = 3'd5;
  localparam logic [2:0] S_EMITN  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] slot_r, slot_nxt;
  logic [6:0] steps_r, steps_nxt;
  logic       kind_r, kind_nxt;
  logic [2:0] status_r, status_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free, accept;
  logic [7:0] nn;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign nn        = {4'd0, stat.n_eff} * {4'd0, stat.n_eff};

  always_comb begin
    state_nxt  = state_r;
    slot_nxt   = slot_r;
    steps_nxt  = steps_r;
    kind_nxt   = kind_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.status = status_r;
    cmd.row    = slot_r;
    case (state_r)
      S_IDLE: begin
        cmd.row = stat.in_proc;
        if (accept) begin
          case (stat.in_type)
            T_CLAIM, T_ALLOC, T_AVAIL: begin
              cmd.load   = 1'b1;
              status_nxt = ST_LOADED;
              state_nxt  = S_EMIT1;
            end
            T_REQUEST: begin
              cmd.load = 1'b1;
              if (stat.in_last) begin
                state_nxt = S_REQ;
              end else begin
                status_nxt = ST_BUFFERED;
                state_nxt  = S_EMIT1;
              end
            end
            T_CHECK: begin
              kind_nxt  = 1'b0;
              state_nxt = S_INIT;
            end
            default: ;
          endcase
        end
      end
      S_REQ: begin
        cmd.row = stat.req_proc;
        if (stat.bad_proc || stat.over) begin
          cmd.clr_buf = 1'b1;
          status_nxt  = ST_EXCEEDS;
          state_nxt   = S_EMIT1;
        end else if (stat.wait_req) begin
          cmd.clr_buf = 1'b1;
          status_nxt  = ST_WAIT;
          state_nxt   = S_EMIT1;
        end else begin
          cmd.grant = 1'b1;
          kind_nxt  = 1'b1;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.safe_init = 1'b1;
        slot_nxt      = 3'd0;
        steps_nxt     = 7'(nn - 8'd1);
        state_nxt     = S_STEP;
      end
      S_STEP: begin
        cmd.safe_step = 1'b1;
        // wrap round robin at the process count
        slot_nxt = ({1'b0, slot_r} + 4'd1 == stat.n_eff) ? 3'd0 : slot_r + 3'd1;
        if (steps_r == 7'd0) state_nxt = S_DONE;
        else steps_nxt = steps_r - 7'd1;
      end
      S_DONE: begin
        cmd.row  = stat.req_proc;
        slot_nxt = 3'd0;
        if (kind_r) begin
          cmd.clr_buf = 1'b1;
          if (stat.all_done) begin
            status_nxt = ST_GRANTED;
          end else begin
            cmd.rollback = 1'b1;
            status_nxt   = ST_REJECTED;
          end
        end else begin
          status_nxt = stat.all_done ? ST_SAFE : ST_UNSAFE;
        end
        state_nxt = S_EMITN;
      end
      S_EMIT1: begin
        if (out_free) begin
          cmd.out_one = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_EMITN: begin
        if (out_free) begin
          cmd.out_rank = 1'b1;
          if ({1'b0, slot_r} == stat.n_eff - 4'd1) state_nxt = S_IDLE;
          else slot_nxt = slot_r + 3'd1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_one || cmd.out_rank) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= 3'd0;
      steps_r     <= 7'd0;
      kind_r      <= 1'b0;
      status_r    <= ST_LOADED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      steps_r     <= steps_nxt;
      kind_r      <= kind_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `BDA_ASSERT_NEXT(a_step_end, state_r == S_STEP && steps_r == 7'd0, state_r == S_DONE, "safety pass overran")
  `BDA_ASSERT_NEXT(a_grant_check, cmd.grant, state_r == S_INIT && kind_r, "grant not followed by safety pass")
  `BDA_ASSERT_NOW(a_rollback_req, cmd.rollback, kind_r && state_r == S_DONE, "rollback outside a request")
  `BDA_ASSERT_NOW(a_out_hold, out_valid_r && !out_tready, !cmd.out_one && !cmd.out_rank, "result overwritten while stalled")

endmodule
